// ===== hw/rtl/sspa_pkg.sv =====
// Shared types, codes and helpers for the sized slot pool allocator.
// No dependencies; imported by sized_slot_pool_allocator_core.
package sspa_pkg;

    localparam int NUM_CLASSES = 4;
    localparam int MAP_W       = 16;

    typedef logic [1:0]       class_t;
    typedef logic [3:0]       slot_t;
    typedef logic [4:0]       count_t;
    typedef logic [MAP_W-1:0] map_t;

    typedef enum logic [1:0] {
        MODE_ACQUIRE = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_STATUS  = 2'd2,
        MODE_SPARE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_RANGE     = 2'd2
    } status_t;

    // Bits 0..size-1 set; size is clamped to 16.
    function automatic map_t class_mask(input count_t size);
        logic [MAP_W:0] one_hot;
        one_hot = (size >= count_t'(MAP_W)) ? {1'b1, {MAP_W{1'b0}}}
                                             : ((MAP_W+1)'(1) << size);
        return map_t'(one_hot - (MAP_W+1)'(1));
    endfunction

    function automatic count_t popcount(input map_t v);
        count_t n;
        n = '0;
        for (int i = 0; i < MAP_W; i++) begin
            n = n + count_t'(v[i]);
        end
        return n;
    endfunction

    // Index of lowest set bit; zero when none is set.
    function automatic slot_t lowest_set(input map_t v);
        slot_t idx;
        idx = '0;
        for (int i = MAP_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = slot_t'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== hw/rtl/sized_slot_pool_allocator_core.sv =====
// Sized slot pool allocator: four size classes of free bitmaps plus wrapping
// attempt and failure counters. Depends on sspa_pkg.
//
// A command is transferred on any edge where start is high (busy stays low:
// a command can be issued every cycle). It is captured in an input register,
// resolved in the following cycle against the bitmaps, and registered in the
// result register; its result shows on the result ports for one cycle with done high.
// Throughput is one command per cycle; each command sees the bitmap updates
// of every earlier one. The receiver cannot stall: a result not taken in its
// done cycle is gone. attempts_total and failures_total are the counter values
// after that command and are valid while done is high.
module sized_slot_pool_allocator_core
    import sspa_pkg::*;
#(
    parameter int SMALL_SLOTS  = 8,
    parameter int MEDIUM_SLOTS = 8,
    parameter int LARGE_SLOTS  = 4,
    parameter int XLARGE_SLOTS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [1:0]  size_class,
    input  logic [3:0]  slot_index,
    output logic        done,
    output logic [1:0]  status,
    output logic [1:0]  granted_class,
    output logic [3:0]  granted_slot,
    output logic [4:0]  free_count,
    output logic [4:0]  used_count,
    output logic [31:0] attempts_total,
    output logic [31:0] failures_total
);

    localparam count_t SIZE [NUM_CLASSES] = '{
        count_t'(SMALL_SLOTS), count_t'(MEDIUM_SLOTS),
        count_t'(LARGE_SLOTS), count_t'(XLARGE_SLOTS)
    };

    // input register
    logic   in_valid_reg;
    mode_t  mode_reg;
    class_t class_reg;
    slot_t  slot_reg;

    // state
    map_t        free_map_reg  [NUM_CLASSES];
    map_t        free_map_next [NUM_CLASSES];
    logic [31:0] attempt_reg, attempt_next;
    logic [31:0] failure_reg, failure_next;

    // result register
    logic    done_reg;
    status_t status_reg, status_next;
    class_t  report_reg, report_next;
    slot_t   gslot_reg, gslot_next;
    count_t  free_reg, free_next;
    count_t  used_reg, used_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mode_reg  <= mode_t'(mode);
            class_reg <= size_class;
            slot_reg  <= slot_index;
        end
    end

    always_comb
    begin
        map_t   avail [NUM_CLASSES];
        map_t   new_map;
        logic   found;
        logic [2:0] tried;
        logic [2:0] full;
        for (int k = 0; k < NUM_CLASSES; k++)
        begin
            free_map_next[k] = free_map_reg[k];
            avail[k]         = free_map_reg[k] & class_mask(SIZE[k]);
        end
        attempt_next = attempt_reg;
        failure_next = failure_reg;
        status_next  = ST_OK;
        report_next  = class_reg;
        gslot_next   = '0;
        found        = 1'b0;
        tried        = '0;
        full         = '0;
        unique case (mode_reg)
            MODE_ACQUIRE:
            begin
                // walk upward from the requested class to the first with room
                for (int k = 0; k < NUM_CLASSES; k++)
                begin
                    if (class_t'(k) >= class_reg && !found)
                    begin
                        tried = tried + 3'd1;
                        if (avail[k] != '0)
                        begin
                            found       = 1'b1;
                            report_next = class_t'(k);
                            gslot_next  = lowest_set(avail[k]);
                            free_map_next[k] = free_map_reg[k]
                                & ~(map_t'(1) << lowest_set(avail[k]));
                        end
                        else
                        begin
                            full = full + 3'd1;
                        end
                    end
                end
                attempt_next = attempt_reg + 32'(tried);
                failure_next = failure_reg + 32'(full);
                if (!found)
                begin
                    status_next = ST_EXHAUSTED;
                end
            end
            MODE_RELEASE:
            begin
                if (count_t'(slot_reg) < SIZE[class_reg])
                begin
                    free_map_next[class_reg] = free_map_reg[class_reg]
                        | (map_t'(1) << slot_reg);
                end
                else
                begin
                    status_next = ST_RANGE;
                end
            end
            default:
            begin
                // status query; the spare mode code behaves the same
            end
        endcase
        new_map   = free_map_next[report_next] & class_mask(SIZE[report_next]);
        free_next = popcount(new_map);
        used_next = SIZE[report_next] - free_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_CLASSES; k++)
            begin
                free_map_reg[k] <= class_mask(SIZE[k]);
            end
            attempt_reg <= '0;
            failure_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                for (int k = 0; k < NUM_CLASSES; k++)
                begin
                    free_map_reg[k] <= free_map_next[k];
                end
                attempt_reg <= attempt_next;
                failure_reg <= failure_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            status_reg <= status_next;
            report_reg <= report_next;
            gslot_reg  <= gslot_next;
            free_reg   <= free_next;
            used_reg   <= used_next;
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign granted_class  = report_reg;
    assign granted_slot   = gslot_reg;
    assign free_count     = free_reg;
    assign used_count     = used_reg;
    assign attempts_total = attempt_reg;
    assign failures_total = failure_reg;

    // every command held in the input register yields one result with done high
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |=> done)
        else $error("result strobe missing");

    a_counts_sum: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (free_count + used_count == SIZE[granted_class]))
        else $error("free and used counts do not add up to class size");

    a_acquire_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && mode_reg == MODE_ACQUIRE)
            |=> (attempts_total != $past(attempts_total)))
        else $error("acquire did not advance attempt counter");

    a_failure_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EXHAUSTED) |-> (failures_total != $past(failures_total)))
        else $error("exhausted acquire without failure count");

endmodule
